// ===== hdl/emt_pkg.sv =====
// Shared types and constants for the encoder multi-turn tracker.
// No dependencies; used by emt_core and encoder_multiturn_tracker.
`timescale 1ns / 1ps

package emt_pkg;

    // Fixed field widths.
    localparam int MAX_STEP_W   = 21;
    localparam int FAIL_LIMIT_W = 4;
    localparam int JUMP_W       = 16;
    localparam int RAW_WORD_W   = 24;
    localparam int CFG_INDEX_W  = 1;

    // Configuration register indexes.
    localparam logic [CFG_INDEX_W-1:0] CFG_MAX_STEP   = 1'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_FAIL_LIMIT = 1'd1;

    // Configuration reset values.
    localparam logic [MAX_STEP_W-1:0]   MAX_STEP_RESET   = 21'd262144;
    localparam logic [FAIL_LIMIT_W-1:0] FAIL_LIMIT_RESET = 4'd5;

    // Result status codes.
    typedef enum logic [1:0] {
        STATUS_FRESH = 2'd0,
        STATUS_HELD  = 2'd1,
        STATUS_FAIL  = 2'd2
    } emt_status_t;

    // Configuration registers as seen by the core.
    typedef struct packed {
        logic [MAX_STEP_W-1:0]   max_step;
        logic [FAIL_LIMIT_W-1:0] fail_limit;
    } emt_cfg_t;

    // Per-result flags passed from the core to the output stage.
    typedef struct packed {
        emt_status_t status;
        logic        step_rejected;
    } emt_flags_t;

endpackage

// ===== hdl/emt_core.sv =====
// Tracker core: holds the multi-turn state and computes one result per item.
// Depends on emt_pkg. Result outputs are combinational; state moves on fire.
`timescale 1ns / 1ps

module emt_core #(
    parameter int ANGLE_BITS    = 21,
    parameter int POSITION_BITS = 48
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  emt_pkg::emt_cfg_t                      cfg,
    input  logic                                   fire,
    input  logic                                   mode,
    input  logic                                   read_ok,
    input  logic [emt_pkg::RAW_WORD_W-1:0]         raw_word,
    output emt_pkg::emt_flags_t                    flags,
    output logic [ANGLE_BITS-1:0]                  angle,
    output logic signed [POSITION_BITS-1:0]        abs_position,
    output logic [emt_pkg::JUMP_W-1:0]             jump_count
);

    localparam int HALF   = 1 << (ANGLE_BITS - 1);
    localparam int TURN   = 1 << ANGLE_BITS;
    localparam int DIFF_W = ANGLE_BITS + 2;
    localparam int CMP_W  = (ANGLE_BITS > emt_pkg::MAX_STEP_W) ? ANGLE_BITS
                                                                : emt_pkg::MAX_STEP_W;
    localparam int SUM_W  = ((POSITION_BITS > ANGLE_BITS + 1) ? POSITION_BITS
                                                              : ANGLE_BITS + 1) + 1;
    localparam logic signed [DIFF_W-1:0] HALF_D = (DIFF_W)'(HALF);
    localparam logic signed [DIFF_W-1:0] TURN_D = (DIFF_W)'(TURN);
    localparam logic [emt_pkg::FAIL_LIMIT_W-1:0] FAIL_COUNT_MAX = '1;

    // Tracker state.
    logic [emt_pkg::FAIL_LIMIT_W-1:0]   fail_count_reg, fail_count_next;
    logic [ANGLE_BITS-1:0]              last_raw_reg, last_raw_next;
    logic [ANGLE_BITS-1:0]              prev_angle_reg, prev_angle_next;
    logic                               origin_ready_reg, origin_ready_next;
    logic signed [POSITION_BITS-1:0]    position_reg, position_next;
    logic [emt_pkg::JUMP_W-1:0]         rejected_total_reg, rejected_total_next;

    // Datapath intermediates.
    logic [ANGLE_BITS-1:0]              raw_new;
    logic [ANGLE_BITS-1:0]              raw_sel;
    logic [ANGLE_BITS-1:0]              ang;
    logic [ANGLE_BITS-1:0]              base;
    logic [emt_pkg::FAIL_LIMIT_W-1:0]   fail_inc;
    logic                               fail_report;
    logic signed [DIFF_W-1:0]           diff;
    logic signed [ANGLE_BITS:0]         step;
    logic [ANGLE_BITS-1:0]              mag;
    logic                               too_big;
    logic signed [SUM_W-1:0]            sum;
    logic                               sum_ovf;
    logic signed [POSITION_BITS-1:0]    pos_sat;
    logic [emt_pkg::JUMP_W-1:0]         rejected_inc;

    // Raw angle is the top bits of the 24-bit register word.
    assign raw_new  = raw_word[emt_pkg::RAW_WORD_W-1 -: ANGLE_BITS];
    assign fail_inc = (fail_count_reg == FAIL_COUNT_MAX) ? fail_count_reg
                                                         : fail_count_reg + 1'b1;
    assign fail_report = !read_ok && (fail_inc > cfg.fail_limit);
    assign raw_sel  = read_ok ? raw_new : last_raw_reg;

    // Polarity inversion modulo one turn.
    assign ang  = ANGLE_BITS'(-raw_sel);
    assign base = origin_ready_reg ? prev_angle_reg : ang;

    // Unwrap the step into [-half turn, +half turn].
    assign diff = $signed({2'b00, ang}) - $signed({2'b00, base});
    always_comb
    begin
        if (diff > HALF_D)
        begin
            step = (ANGLE_BITS + 1)'(diff - TURN_D);
        end
        else if (diff < -HALF_D)
        begin
            step = (ANGLE_BITS + 1)'(diff + TURN_D);
        end
        else
        begin
            step = (ANGLE_BITS + 1)'(diff);
        end
    end

    // Step magnitude check against the configured limit.
    assign mag     = step[ANGLE_BITS] ? ANGLE_BITS'(-step) : ANGLE_BITS'(step);
    assign too_big = CMP_W'(mag) > CMP_W'(cfg.max_step);

    // Saturating position update.
    assign sum     = SUM_W'(position_reg) + SUM_W'(step);
    assign sum_ovf = !((&sum[SUM_W-1:POSITION_BITS-1]) || !(|sum[SUM_W-1:POSITION_BITS-1]));
    assign pos_sat = sum[SUM_W-1] ? {1'b1, {(POSITION_BITS-1){1'b0}}}
                                  : {1'b0, {(POSITION_BITS-1){1'b1}}};
    assign rejected_inc = (rejected_total_reg == '1) ? rejected_total_reg
                                                     : rejected_total_reg + 1'b1;

    // Result selection and next state.
    always_comb
    begin
        fail_count_next     = fail_count_reg;
        last_raw_next       = last_raw_reg;
        prev_angle_next     = prev_angle_reg;
        origin_ready_next   = origin_ready_reg;
        position_next       = position_reg;
        rejected_total_next = rejected_total_reg;

        flags.status        = read_ok ? emt_pkg::STATUS_FRESH : emt_pkg::STATUS_HELD;
        flags.step_rejected = 1'b0;
        angle               = ang;
        abs_position        = position_reg;
        jump_count          = rejected_total_reg;

        if (mode)
        begin
            // Rebase: zero the position and take the next sample as origin.
            position_next     = '0;
            origin_ready_next = 1'b0;
            flags.status      = emt_pkg::STATUS_FRESH;
            angle             = '0;
            abs_position      = '0;
        end
        else if (fail_report)
        begin
            fail_count_next = fail_inc;
            flags.status    = emt_pkg::STATUS_FAIL;
            angle           = '0;
        end
        else
        begin
            if (read_ok)
            begin
                fail_count_next = '0;
                last_raw_next   = raw_new;
            end
            else
            begin
                fail_count_next = fail_inc;
            end
            origin_ready_next = 1'b1;
            if (!origin_ready_reg)
            begin
                prev_angle_next = ang;
            end

            if (too_big)
            begin
                rejected_total_next = rejected_inc;
                flags.step_rejected = 1'b1;
                jump_count          = rejected_inc;
            end
            else
            begin
                position_next   = sum_ovf ? pos_sat : POSITION_BITS'(sum);
                prev_angle_next = ang;
                abs_position    = position_next;
            end
        end
    end

    // State registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fail_count_reg     <= '0;
            last_raw_reg       <= '0;
            prev_angle_reg     <= '0;
            origin_ready_reg   <= 1'b0;
            position_reg       <= '0;
            rejected_total_reg <= '0;
        end
        else if (fire)
        begin
            fail_count_reg     <= fail_count_next;
            last_raw_reg       <= last_raw_next;
            prev_angle_reg     <= prev_angle_next;
            origin_ready_reg   <= origin_ready_next;
            position_reg       <= position_next;
            rejected_total_reg <= rejected_total_next;
        end
    end

endmodule

// ===== hdl/encoder_multiturn_tracker.sv =====
// Absolute encoder multi-turn tracker: top level with stream ports and config.
// Depends on emt_pkg and emt_core.
`timescale 1ns / 1ps

// The tracker takes one item per clock cycle while the output side is not stalled,
// and returns one result item for each. An item first lands in an input register;
// from there it passes once through the core (angle inversion, unwrap, step check
// and saturating position add) into the result register. The input register can
// take one more item while a finished result waits; once both registers are full,
// the input stalls until the result is taken. The tracking state updates as each
// item passes the core, so back-to-back items see each other's effect in order.
// Configuration writes take effect at once and are meant to be made while no item
// is in flight.

module encoder_multiturn_tracker #(
    parameter int ANGLE_BITS    = 21,
    parameter int POSITION_BITS = 48
) (
    input  logic                                    clk,
    input  logic                                    rst_n,

    // Configuration write port.
    input  logic                                    cfg_we,
    input  logic [emt_pkg::CFG_INDEX_W-1:0]         cfg_index,
    input  logic [emt_pkg::MAX_STEP_W-1:0]          cfg_data,

    // Input stream.
    input  logic                                    s_axis_tvalid,
    output logic                                    s_axis_tready,
    input  logic [23:0]                             s_axis_tdata,  // byte_high, byte_middle, byte_low
    input  logic [1:0]                              s_axis_tuser,  // mode, read_ok

    // Result stream.
    output logic                                    m_axis_tvalid,
    input  logic                                    m_axis_tready,
    output logic [((ANGLE_BITS + POSITION_BITS + emt_pkg::JUMP_W + 7) / 8) * 8 - 1:0]
                                                    m_axis_tdata,  // angle, abs_position, jump_count
    output logic [2:0]                              m_axis_tuser   // status, step_rejected
);

    localparam int OUT_W = ((ANGLE_BITS + POSITION_BITS + emt_pkg::JUMP_W + 7) / 8) * 8;

    // Configuration registers.
    emt_pkg::emt_cfg_t                  cfg_reg;

    // Input register.
    logic                               in_valid_reg;
    logic                               in_mode_reg;
    logic                               in_ok_reg;
    logic [emt_pkg::RAW_WORD_W-1:0]     in_word_reg;

    // Result register.
    logic                               out_valid_reg;
    emt_pkg::emt_flags_t                out_flags_reg;
    logic [ANGLE_BITS-1:0]              out_angle_reg;
    logic signed [POSITION_BITS-1:0]    out_pos_reg;
    logic [emt_pkg::JUMP_W-1:0]         out_jump_reg;

    // Core results.
    emt_pkg::emt_flags_t                core_flags;
    logic [ANGLE_BITS-1:0]              core_angle;
    logic signed [POSITION_BITS-1:0]    core_pos;
    logic [emt_pkg::JUMP_W-1:0]         core_jump;

    logic                               load_in;
    logic                               advance;

    // Handshake control.
    assign advance       = in_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || advance;
    assign load_in       = s_axis_tvalid && s_axis_tready;

    // Configuration writes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.max_step   <= emt_pkg::MAX_STEP_RESET;
            cfg_reg.fail_limit <= emt_pkg::FAIL_LIMIT_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                emt_pkg::CFG_MAX_STEP:
                begin
                    cfg_reg.max_step <= cfg_data;
                end
                emt_pkg::CFG_FAIL_LIMIT:
                begin
                    cfg_reg.fail_limit <= cfg_data[emt_pkg::FAIL_LIMIT_W-1:0];
                end
                default:
                begin
                    cfg_reg <= cfg_reg;
                end
            endcase
        end
    end

    // Input register valid.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (load_in)
        begin
            in_valid_reg <= 1'b1;
        end
        else if (advance)
        begin
            in_valid_reg <= 1'b0;
        end
    end

    // Input register payload.
    always_ff @(posedge clk)
    begin
        if (load_in)
        begin
            in_mode_reg <= s_axis_tuser[0];
            in_ok_reg   <= s_axis_tuser[1];
            in_word_reg <= {s_axis_tdata[7:0], s_axis_tdata[15:8], s_axis_tdata[23:16]};
        end
    end

    emt_core #(
        .ANGLE_BITS    (ANGLE_BITS),
        .POSITION_BITS (POSITION_BITS)
    ) u_core (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (cfg_reg),
        .fire         (advance),
        .mode         (in_mode_reg),
        .read_ok      (in_ok_reg),
        .raw_word     (in_word_reg),
        .flags        (core_flags),
        .angle        (core_angle),
        .abs_position (core_pos),
        .jump_count   (core_jump)
    );

    // Result register valid.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // Result register payload.
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_flags_reg <= core_flags;
            out_angle_reg <= core_angle;
            out_pos_reg   <= core_pos;
            out_jump_reg  <= core_jump;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = OUT_W'({out_jump_reg, out_pos_reg, out_angle_reg});
    assign m_axis_tuser  = {out_flags_reg.step_rejected, out_flags_reg.status};

    // A reported failure carries no angle and never a rejected step.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && (out_flags_reg.status == emt_pkg::STATUS_FAIL)
        |-> (out_angle_reg == '0) && !out_flags_reg.step_rejected)
        else $error("failure result with nonzero angle or rejected step");

    // A rejected step has always been counted.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_flags_reg.step_rejected |-> (out_jump_reg != '0))
        else $error("rejected step with zero jump count");

    // An empty input register always takes a new item.
    assert property (@(posedge clk) disable iff (!rst_n)
        !in_valid_reg |-> s_axis_tready)
        else $error("input stalled while input register is empty");

    // A stalled result holds while the input register keeps its item.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !m_axis_tready && in_valid_reg |=> in_valid_reg && out_valid_reg)
        else $error("item lost during output stall");

endmodule

// ===== test/testbench.sv =====
// Self-checking testbench for encoder_multiturn_tracker: stream stimulus, an in-line
// tracker predictor and a result checker. Depends on emt_pkg and the tracker RTL.
`timescale 1ns / 1ps

module testbench;

    localparam int ANGLE_W     = 21;
    localparam int POS_W       = 48;
    localparam int ANGLE_MASK  = (1 << ANGLE_W) - 1;
    localparam longint TURN      = longint'(1) << ANGLE_W;
    localparam longint HALF_TURN = TURN / 2;
    localparam longint POS_MAX   = (longint'(1) << (POS_W - 1)) - 1;
    localparam longint POS_MIN   = -POS_MAX - 1;
    localparam int FAIL_SAT    = 15;
    localparam int JUMP_SAT    = 65535;
    localparam int DATA_OUT_W  = ((ANGLE_W + POS_W + emt_pkg::JUMP_W + 7) / 8) * 8;
    localparam int POS_LSB     = ANGLE_W;
    localparam int JUMP_LSB    = ANGLE_W + POS_W;
    localparam int STALL_LIMIT = 5000;
    localparam int MAX_PRINTED = 100;

    // One expected result item.
    typedef struct {
        emt_pkg::emt_status_t         status;
        logic [ANGLE_W-1:0]           angle;
        logic [POS_W-1:0]             position;
        logic                         rejected;
        logic [emt_pkg::JUMP_W-1:0]   jumps;
    } tracker_result_t;

    logic                             clk;
    logic                             rst_n;
    logic                             cfg_we;
    logic [emt_pkg::CFG_INDEX_W-1:0]  cfg_index;
    logic [emt_pkg::MAX_STEP_W-1:0]   cfg_data;
    logic                             s_axis_tvalid;
    logic                             s_axis_tready;
    logic [23:0]                      s_axis_tdata;   // byte_high, byte_middle, byte_low
    logic [1:0]                       s_axis_tuser;   // mode, read_ok
    logic                             m_axis_tvalid;
    logic                             m_axis_tready;
    logic [DATA_OUT_W-1:0]            m_axis_tdata;   // angle, abs_position, jump_count
    logic [2:0]                       m_axis_tuser;   // status, step_rejected

    // Predictor copy of the configuration and tracking state.
    int      cfg_max_step   = emt_pkg::MAX_STEP_RESET;
    int      cfg_fail_limit = emt_pkg::FAIL_LIMIT_RESET;
    int      trk_fail_count = 0;
    logic [ANGLE_W-1:0] trk_last_raw   = '0;
    logic [ANGLE_W-1:0] trk_prev_angle = '0;
    logic    trk_origin_ready = 1'b0;
    longint  trk_position     = 0;
    int      trk_jumps        = 0;

    tracker_result_t pending_results[$];

    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int items_sent    = 0;
    int results_seen  = 0;
    int mismatch_count = 0;
    int quiet_cycles  = 0;
    int fresh_total   = 0;
    int held_total    = 0;
    int failed_total  = 0;
    int rebase_total  = 0;
    int reject_total  = 0;

    encoder_multiturn_tracker u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    // Clock.
    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // Tracker predictor: applies one event to the state and returns its result.
    function automatic tracker_result_t track_event(input logic mode, input logic read_ok,
                                                    input logic [23:0] word);
        tracker_result_t    res;
        logic [ANGLE_W-1:0] raw;
        logic [ANGLE_W-1:0] ang;
        longint             step;
        longint             mag;
        res.status   = emt_pkg::STATUS_FRESH;
        res.angle    = '0;
        res.rejected = 1'b0;
        // A rebase clears the position and makes the next sample the origin.
        if (mode)
        begin
            trk_position     = 0;
            trk_origin_ready = 1'b0;
            res.position     = '0;
            res.jumps        = trk_jumps[emt_pkg::JUMP_W-1:0];
            return res;
        end
        if (read_ok)
        begin
            raw            = word[23 -: ANGLE_W];
            trk_fail_count = 0;
            trk_last_raw   = raw;
        end
        else
        begin
            // Failed read: reuse the last raw angle until the limit is passed.
            if (trk_fail_count < FAIL_SAT)
                trk_fail_count++;
            if (trk_fail_count > cfg_fail_limit)
            begin
                res.status   = emt_pkg::STATUS_FAIL;
                res.position = trk_position[POS_W-1:0];
                res.jumps    = trk_jumps[emt_pkg::JUMP_W-1:0];
                return res;
            end
            raw        = trk_last_raw;
            res.status = emt_pkg::STATUS_HELD;
        end
        ang       = ANGLE_W'(0) - raw;
        res.angle = ang;
        if (!trk_origin_ready)
        begin
            trk_prev_angle   = ang;
            trk_origin_ready = 1'b1;
        end
        // Unwrap to the shortest step; a step of exactly half a turn keeps its sign.
        step = longint'(ang) - longint'(trk_prev_angle);
        if (step > HALF_TURN)
            step -= TURN;
        else if (step < -HALF_TURN)
            step += TURN;
        mag = (step < 0) ? -step : step;
        if (mag > longint'(cfg_max_step))
        begin
            if (trk_jumps < JUMP_SAT)
                trk_jumps++;
            res.rejected = 1'b1;
        end
        else
        begin
            if (step > 0 && trk_position > POS_MAX - step)
                trk_position = POS_MAX;
            else if (step < 0 && trk_position < POS_MIN - step)
                trk_position = POS_MIN;
            else
                trk_position += step;
            trk_prev_angle = ang;
        end
        res.position = trk_position[POS_W-1:0];
        res.jumps    = trk_jumps[emt_pkg::JUMP_W-1:0];
        return res;
    endfunction

    // Sends one item, with random idle cycles ahead of it, and queues its result.
    task automatic send_item(input logic mode, input logic read_ok, input logic [23:0] word);
        tracker_result_t want;
        @(negedge clk);
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= {read_ok, mode};
        s_axis_tdata  <= {word[7:0], word[15:8], word[23:16]};
        do
            @(posedge clk);
        while (!s_axis_tready);
        want = track_event(mode, read_ok, word);
        pending_results.push_back(want);
        items_sent++;
        if (mode)
            rebase_total++;
        else if (want.status == emt_pkg::STATUS_FAIL)
            failed_total++;
        else if (want.status == emt_pkg::STATUS_HELD)
            held_total++;
        else
            fresh_total++;
        if (want.rejected)
            reject_total++;
    endtask

    // Good read of a given raw angle; the unused low bits are random.
    task automatic send_sample(input logic [ANGLE_W-1:0] raw);
        send_item(1'b0, 1'b1, {raw, 3'($urandom)});
    endtask

    // Stops the sender until every expected result has come back.
    task automatic drain_results();
        @(negedge clk);
        s_axis_tvalid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // Writes one configuration register while the block is idle.
    task automatic write_config(input logic [emt_pkg::CFG_INDEX_W-1:0] idx,
                                input logic [emt_pkg::MAX_STEP_W-1:0] value);
        drain_results();
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(negedge clk);
        cfg_we    <= 1'b0;
        if (idx == emt_pkg::CFG_MAX_STEP)
            cfg_max_step = value;
        else
            cfg_fail_limit = value[emt_pkg::FAIL_LIMIT_W-1:0];
    endtask

    // Prints one mismatch line and counts it.
    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        mismatch_count++;
        if (mismatch_count <= MAX_PRINTED)
            $display("%0t: result %0d %s: got 0x%0h, expected 0x%0h",
                     $time, results_seen, what, got, want);
    endtask

    // Field extremes, junk in the unused low bits and the step limit at reset values.
    task automatic test_turn_extremes();
        send_item(1'b0, 1'b1, 24'h000000);
        send_item(1'b0, 1'b1, 24'hFFFFFF);
        send_item(1'b0, 1'b1, 24'h000007);
        send_sample(21'h100000);
        send_sample(21'h040000);
        send_sample(21'h040001);
    endtask

    // Failed reads: held raw up to the limit, then failure, then recovery.
    task automatic test_failed_reads();
        repeat (6) send_item(1'b0, 1'b0, 24'($urandom));
        send_sample(21'h040001);
    endtask

    // Rebase zeroes the position; the next sample becomes the origin.
    task automatic test_rebase();
        send_item(1'b1, 1'b1, 24'hFFFFFF);
        send_sample(21'h1ABCDE);
        send_sample(21'h1ABCDD);
    endtask

    // Register extremes: half-turn steps both ways, wrap, no-tolerance and zero step.
    task automatic test_step_limits();
        write_config(emt_pkg::CFG_MAX_STEP, 21'd1048576);
        write_config(emt_pkg::CFG_FAIL_LIMIT, 21'd0);
        send_sample(21'h000000);
        send_sample(21'h100000);
        send_sample(21'h000000);
        send_sample(21'h0FFFFF);
        send_item(1'b0, 1'b0, 24'($urandom));
        write_config(emt_pkg::CFG_MAX_STEP, 21'd0);
        write_config(emt_pkg::CFG_FAIL_LIMIT, 21'd14);
        send_sample(21'h0FFFFF);
        send_sample(21'h100000);
        send_item(1'b0, 1'b0, 24'($urandom));
    endtask

    // Random traffic: mostly a wandering angle with steps around max_step,
    // plus failed-read bursts, rebases and arbitrary items.
    task automatic test_random_traffic(input int n_items);
        int          sent;
        int          pick;
        int          span;
        int          delta;
        int          walk;
        logic [23:0] word;
        bit          paused;
        sent   = 0;
        paused = 1'b0;
        walk   = $urandom_range(ANGLE_MASK);
        while (sent < n_items)
        begin
            // Once per phase, hold off until the block has emptied.
            if (!paused && sent >= n_items / 2)
            begin
                drain_results();
                paused = 1'b1;
            end
            pick = $urandom_range(99);
            if (pick < 68)
            begin
                span  = cfg_max_step + cfg_max_step / 4 + 8;
                delta = $urandom_range(span);
                if ($urandom_range(1))
                    delta = -delta;
                walk = (walk + delta) & ANGLE_MASK;
                send_sample(walk[ANGLE_W-1:0]);
                sent++;
            end
            else if (pick < 80)
            begin
                repeat ($urandom_range(1, 17))
                begin
                    send_item(1'b0, 1'b0, 24'($urandom));
                    sent++;
                end
            end
            else if (pick < 86)
            begin
                send_item(1'b1, 1'($urandom), 24'($urandom));
                sent++;
            end
            else
            begin
                word = 24'($urandom);
                walk = int'(word[23 -: ANGLE_W]);
                send_item(pick >= 96 ? 1'($urandom) : 1'b0, pick >= 96 ? 1'($urandom) : 1'b1,
                          word);
                sent++;
            end
        end
    endtask

    // Receiver stalls, redrawn every cycle.
    initial
    begin
        m_axis_tready = 1'b0;
        forever
        begin
            @(negedge clk);
            m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // Result checker: compares each accepted result with the oldest expectation.
    always @(posedge clk)
    begin
        tracker_result_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            results_seen++;
            if (pending_results.size() == 0)
                report_mismatch("unexpected result", 64'(m_axis_tdata), 64'd0);
            else
            begin
                want = pending_results.pop_front();
                if (m_axis_tuser[1:0] !== want.status)
                    report_mismatch("status", 64'(m_axis_tuser[1:0]), 64'(want.status));
                if (m_axis_tuser[2] !== want.rejected)
                    report_mismatch("step_rejected", 64'(m_axis_tuser[2]), 64'(want.rejected));
                if (m_axis_tdata[0 +: ANGLE_W] !== want.angle)
                    report_mismatch("angle", 64'(m_axis_tdata[0 +: ANGLE_W]), 64'(want.angle));
                if (m_axis_tdata[POS_LSB +: POS_W] !== want.position)
                    report_mismatch("abs_position", 64'(m_axis_tdata[POS_LSB +: POS_W]),
                                    64'(want.position));
                if (m_axis_tdata[JUMP_LSB +: emt_pkg::JUMP_W] !== want.jumps)
                    report_mismatch("jump_count",
                                    64'(m_axis_tdata[JUMP_LSB +: emt_pkg::JUMP_W]),
                                    64'(want.jumps));
            end
        end
    end

    // Watchdog: ends the run when nothing moves on either side for too long.
    always @(posedge clk)
    begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            quiet_cycles = 0;
        else
        begin
            quiet_cycles++;
            if (quiet_cycles >= STALL_LIMIT)
            begin
                $display("Timeout: no item moved for %0d cycles, %0d results outstanding",
                         STALL_LIMIT, pending_results.size());
                $display("CHECKS FAILED");
                $finish;
            end
        end
    end

    // Test sequence.
    initial
    begin
        rst_n         = 1'b0;
        cfg_we        = 1'b0;
        cfg_index     = emt_pkg::CFG_MAX_STEP;
        cfg_data      = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = '0;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Sender rarely idles, receiver mostly stalls.
        send_idle_pct = 6;
        recv_idle_pct = 79;
        test_turn_extremes();
        test_failed_reads();
        test_rebase();
        test_step_limits();
        write_config(emt_pkg::CFG_MAX_STEP, 21'($urandom_range(1024, 262144)));
        write_config(emt_pkg::CFG_FAIL_LIMIT, 21'($urandom_range(1, 13)));
        test_random_traffic(600);

        // Sender mostly idles, receiver rarely stalls.
        send_idle_pct = 79;
        recv_idle_pct = 6;
        write_config(emt_pkg::CFG_MAX_STEP, 21'd1048576);
        write_config(emt_pkg::CFG_FAIL_LIMIT, 21'd14);
        test_random_traffic(550);

        // Full rate on both sides.
        send_idle_pct = 0;
        recv_idle_pct = 0;
        write_config(emt_pkg::CFG_MAX_STEP, 21'($urandom_range(0, 1048576)));
        write_config(emt_pkg::CFG_FAIL_LIMIT, 21'd0);
        test_random_traffic(550);

        drain_results();
        repeat (8) @(posedge clk);
        $display("Run covered %0d items: %0d fresh, %0d held, %0d failed, %0d rebase.",
                 items_sent, fresh_total, held_total, failed_total, rebase_total);
        $display("%0d steps rejected; max_step 0 to half a turn, fail_limit 0 to 14.",
                 reject_total);
        if (mismatch_count == 0 && pending_results.size() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
